[rtl/core/bbe_pkg.sv]
// Shared types, widths and helpers for the B-spline basis evaluator.
package bbe_pkg;

    localparam int BBE_MAX_DEGREE = 3;
    localparam int BBE_KNOT_DEPTH = 64;

    localparam int KNOT_W = 32;
    localparam int VAL_W  = 31;
    localparam int PROD_W = 63;
    localparam int DEN_W  = 33;
    localparam int Q_W    = 31;

    localparam logic [VAL_W-1:0] ONE_Q30 = 31'h4000_0000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDL,
        ST_RDR,
        ST_DIFF,
        ST_MUL,
        ST_DGO,
        ST_DWAIT,
        ST_UPD,
        ST_EMIT
    } state_t;

    function automatic logic [KNOT_W-1:0] sat_sub(input logic [KNOT_W-1:0] a,
                                                  input logic [KNOT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

[rtl/core/bspline_basis_eval.sv]
// Top level of the B-spline basis evaluator: knot store, sequencer and datapath.
//
//   Channel   Handshake              Words
//   input     start & !busy          knot write or evaluate request
//   result    result_valid strobe    one basis value, or one error word
//
// A knot write leaves busy low. An evaluation holds busy high for its whole
// run; each recurrence term costs two multiplies and, unless its denominator
// is zero, two divisions on the shared divider.
// Reset clears the sequencer and the result strobe; the knot store is not cleared.
// Words of a level are issued one per cycle; the receiver cannot hold them off.
module bspline_basis_eval
    import bbe_pkg::*;
#(
    parameter int MAX_DEGREE = BBE_MAX_DEGREE,
    parameter int KNOT_DEPTH = BBE_KNOT_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [5:0]        knot_index,
    input  logic [31:0]       knot_value,
    input  logic [31:0]       param_u,
    input  logic [5:0]        span,
    input  logic [1:0]        degree,
    input  logic              all_levels,
    output logic              result_valid,
    output logic [1:0]        level,
    output logic [1:0]        func_index,
    output logic [VAL_W-1:0]  basis_value,
    output logic              error,
    output logic              last
);

    localparam int LW = $clog2(MAX_DEGREE + 1);
    localparam int AW = $clog2(KNOT_DEPTH);
    localparam int XW = ((AW > 6) ? AW : 6) + 2;

    logic [KNOT_W-1:0] knot_mem [0:KNOT_DEPTH-1];
    logic [KNOT_W-1:0] knot_rd_reg;
    logic [VAL_W-1:0]  basis_reg [0:MAX_DEGREE];
    logic [KNOT_W-1:0] left_diffs_reg [0:MAX_DEGREE];
    logic [KNOT_W-1:0] right_diffs_reg [0:MAX_DEGREE];

    state_t            state_reg, state_next;
    logic [LW-1:0]     i_reg, i_next;
    logic [LW-1:0]     r_reg, r_next;
    logic [LW-1:0]     n_reg, n_next;
    logic              phase_reg, phase_next;
    logic [LW-1:0]     deg_reg;
    logic              all_reg;
    logic [31:0]       u_reg;
    logic [5:0]        span_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [Q_W-1:0]    rpart_reg;
    logic [Q_W-1:0]    lpart_reg;
    logic [Q_W-1:0]    saved_reg;

    logic              accept;
    logic [LW-1:0]     deg_in;
    logic [XW-1:0]     span_x;
    logic [XW-1:0]     deg_x;
    logic [XW-1:0]     kidx_x;
    logic [XW-1:0]     rd_addr_x;
    logic              span_err;
    logic [LW-1:0]     bidx;
    logic [LW-1:0]     lidx;
    logic [LW-1:0]     ridx;
    logic [KNOT_W-1:0] mul_op;
    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    div_q;

    logic              valid_reg;
    logic [1:0]        level_reg;
    logic [1:0]        func_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              error_reg;
    logic              last_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign deg_in   = (int'(degree) > MAX_DEGREE) ? LW'(MAX_DEGREE) : LW'(degree);
    assign span_x   = XW'(span);
    assign deg_x    = XW'(deg_in);
    assign kidx_x   = XW'(knot_index);
    assign span_err = (span_x < deg_x) || ((span_x + deg_x) >= XW'(KNOT_DEPTH));

    assign rd_addr_x = (state_reg == ST_RDL) ? (XW'(span_reg) + XW'(1) - XW'(i_reg))
                                             : (XW'(span_reg) + XW'(i_reg));

    assign bidx   = (state_reg == ST_EMIT) ? n_reg : r_reg;
    assign lidx   = i_reg - r_reg;
    assign ridx   = r_reg + LW'(1);
    assign mul_op = phase_reg ? left_diffs_reg[lidx] : right_diffs_reg[ridx];

    always_ff @(posedge clk)
    begin
        if (accept && (kind == KIND_WRITE) && (kidx_x < XW'(KNOT_DEPTH)))
        begin
            knot_mem[kidx_x[AW-1:0]] <= knot_value;
        end
        knot_rd_reg <= knot_mem[rd_addr_x[AW-1:0]];
    end

    bbe_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            r_reg     <= '0;
            n_reg     <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            r_reg     <= r_next;
            n_reg     <= n_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        phase_next = phase_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_EVAL) && !span_err)
                begin
                    n_next = '0;
                    r_next = '0;
                    if (all_levels || (deg_in == '0))
                    begin
                        i_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next     = LW'(1);
                        state_next = ST_RDL;
                    end
                end
            end
            ST_RDL:
            begin
                state_next = ST_RDR;
            end
            ST_RDR:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                r_next     = '0;
                phase_next = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DGO;
            end
            ST_DGO:
            begin
                if (den_reg == '0)
                begin
                    phase_next = 1'b1;
                    state_next = phase_reg ? ST_UPD : ST_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DWAIT;
                end
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    phase_next = 1'b1;
                    state_next = phase_reg ? ST_UPD : ST_MUL;
                end
            end
            ST_UPD:
            begin
                phase_next = 1'b0;
                if (r_reg == (i_reg - LW'(1)))
                begin
                    if (all_reg || (i_reg == deg_reg))
                    begin
                        n_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + LW'(1);
                        state_next = ST_RDL;
                    end
                end
                else
                begin
                    r_next     = r_reg + LW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                n_next = n_reg + LW'(1);
                if (n_reg == i_reg)
                begin
                    if (i_reg == deg_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + LW'(1);
                        state_next = ST_RDL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_EVAL))
                begin
                    u_reg        <= param_u;
                    span_reg     <= span;
                    deg_reg      <= deg_in;
                    all_reg      <= all_levels;
                    basis_reg[0] <= ONE_Q30;
                end
            end
            ST_RDR:
            begin
                left_diffs_reg[i_reg] <= sat_sub(u_reg, knot_rd_reg);
            end
            ST_DIFF:
            begin
                right_diffs_reg[i_reg] <= sat_sub(knot_rd_reg, u_reg);
                saved_reg              <= '0;
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(basis_reg[bidx]) * PROD_W'(mul_op);
                den_reg  <= DEN_W'(right_diffs_reg[ridx]) + DEN_W'(left_diffs_reg[lidx]);
            end
            ST_DGO:
            begin
                if (den_reg == '0)
                begin
                    if (phase_reg)
                    begin
                        lpart_reg <= '0;
                    end
                    else
                    begin
                        rpart_reg <= '0;
                    end
                end
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (phase_reg)
                    begin
                        lpart_reg <= div_q;
                    end
                    else
                    begin
                        rpart_reg <= div_q;
                    end
                end
            end
            ST_UPD:
            begin
                basis_reg[r_reg] <= VAL_W'(saved_reg + rpart_reg);
                saved_reg        <= lpart_reg;
                if (r_reg == (i_reg - LW'(1)))
                begin
                    basis_reg[i_reg] <= lpart_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= (accept && (kind == KIND_EVAL) && span_err) ||
                         (state_reg == ST_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            level_reg <= 2'(i_reg);
            func_reg  <= 2'(n_reg);
            value_reg <= basis_reg[bidx];
            error_reg <= 1'b0;
            last_reg  <= (n_reg == i_reg) && (i_reg == deg_reg);
        end
        else
        begin
            level_reg <= 2'(deg_in);
            func_reg  <= '0;
            value_reg <= '0;
            error_reg <= 1'b1;
            last_reg  <= 1'b1;
        end
    end

    assign result_valid = valid_reg;
    assign level        = level_reg;
    assign func_index   = func_reg;
    assign basis_value  = value_reg;
    assign error        = error_reg;
    assign last         = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error) |-> (last && (basis_value == '0)))
        else $error("error word must be final and zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (basis_value <= ONE_Q30))
        else $error("basis value above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DWAIT))
        else $error("divider finished while sequencer was not waiting");

endmodule

[rtl/core/bbe_div.sv]
// Bit-serial restoring divider shared by every recurrence step.
module bbe_div
    import bbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic              done,
    output logic [Q_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   div_x;
    logic             ge;

    assign trial = {rem_reg, low_reg[Q_W-1]};
    assign div_x = {1'b0, divisor};
    assign ge    = (trial >= div_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(Q_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(dividend[PROD_W-1:Q_W]);
            low_reg <= dividend[Q_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DEN_W'(trial - div_x) : DEN_W'(trial);
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sim/bspline_basis_eval_tb.sv]
// Testbench for bspline_basis_eval: directed and random words, checked by table or predictor.
module bspline_basis_eval_tb
    import bbe_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       lvl;
        logic [1:0]       fidx;
        logic [VAL_W-1:0] val;
        logic             err;
        logic             fin;
    } basis_word_t;

    typedef struct {
        logic              knd;
        logic [5:0]        idx;
        logic [KNOT_W-1:0] kval;
        logic [KNOT_W-1:0] u;
        logic [5:0]        sp;
        logic [1:0]        dg;
        logic              all;
        logic              typed;
        basis_word_t       exp_word;
    } stim_row_t;

    localparam int NUM_ROWS    = 22;
    localparam int CYCLE_LIMIT = 2000000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              kind;
    logic [5:0]        knot_index;
    logic [31:0]       knot_value;
    logic [31:0]       param_u;
    logic [5:0]        span;
    logic [1:0]        degree;
    logic              all_levels;
    logic              result_valid;
    logic [1:0]        level;
    logic [1:0]        func_index;
    logic [VAL_W-1:0]  basis_value;
    logic              error;
    logic              last;

    logic [KNOT_W-1:0] knot_copy [BBE_KNOT_DEPTH];
    logic              knot_known [BBE_KNOT_DEPTH];
    basis_word_t       pending_basis [$];
    stim_row_t         dir_table [NUM_ROWS];
    int                mismatches = 0;
    int                cycles = 0;
    int                idle_pct;

    bspline_basis_eval dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .knot_index(knot_index), .knot_value(knot_value), .param_u(param_u),
        .span(span), .degree(degree), .all_levels(all_levels),
        .result_valid(result_valid), .level(level), .func_index(func_index),
        .basis_value(basis_value), .error(error), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("bspline_basis_eval: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        basis_word_t got;
        basis_word_t want;
        if (rst_n && result_valid)
        begin
            got = '{level, func_index, basis_value, error, last};
            if (pending_basis.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: lvl=%0d idx=%0d val=%h err=%b last=%b",
                             level, func_index, basis_value, error, last);
            end
            else
            begin
                want = pending_basis.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("word mismatch: exp lvl=%0d idx=%0d val=%h err=%b last=%b",
                                 want.lvl, want.fidx, want.val, want.err, want.fin);
                        $display("               got lvl=%0d idx=%0d val=%h err=%b last=%b",
                                 got.lvl, got.fidx, got.val, got.err, got.fin);
                    end
                end
            end
        end
    end

    // Cox-de Boor triangle in fixed point; pushes every word the evaluation emits.
    task automatic predict_basis(input logic [KNOT_W-1:0] u, input int sp, input int dg,
                                 input logic all);
        logic [VAL_W-1:0]  nb [BBE_MAX_DEGREE+1];
        logic [KNOT_W-1:0] lft [BBE_MAX_DEGREE+1];
        logic [KNOT_W-1:0] rgt [BBE_MAX_DEGREE+1];
        longint unsigned   saved, rt, lt, den, nv, rp, lp;
        logic [KNOT_W-1:0] kn;
        int                total, k;
        if (sp < dg || sp + dg >= BBE_KNOT_DEPTH)
        begin
            pending_basis.push_back('{dg[1:0], 2'd0, '0, 1'b1, 1'b1});
            return;
        end
        total = all ? (dg + 1) * (dg + 2) / 2 : dg + 1;
        k = 0;
        nb[0] = ONE_Q30;
        if (all || dg == 0)
        begin
            pending_basis.push_back('{2'd0, 2'd0, ONE_Q30, 1'b0, k + 1 == total});
            k++;
        end
        for (int i = 1; i <= dg; i++)
        begin
            kn = knot_copy[sp + 1 - i];
            lft[i] = (u > kn) ? u - kn : '0;
            kn = knot_copy[sp + i];
            rgt[i] = (kn > u) ? kn - u : '0;
            saved = 0;
            for (int r = 0; r < i; r++)
            begin
                rt = rgt[r + 1];
                lt = lft[i - r];
                den = rt + lt;
                nv = nb[r];
                rp = 0;
                lp = 0;
                if (den != 0)
                begin
                    rp = (nv * rt) / den;
                    lp = (nv * lt) / den;
                end
                nb[r] = VAL_W'(saved + rp);
                saved = lp;
            end
            nb[i] = VAL_W'(saved);
            if (all || i == dg)
                for (int n = 0; n <= i; n++)
                begin
                    pending_basis.push_back('{i[1:0], n[1:0], nb[n], 1'b0, k + 1 == total});
                    k++;
                end
        end
    endtask

    // Called on a falling edge; returns on one after the word is taken and any idle gap.
    task automatic issue_word(input stim_row_t row);
        kind = row.knd;
        knot_index = row.idx;
        knot_value = row.kval;
        param_u = row.u;
        span = row.sp;
        degree = row.dg;
        all_levels = row.all;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        if (row.knd == KIND_WRITE)
        begin
            knot_copy[row.idx] = row.kval;
            knot_known[row.idx] = 1'b1;
        end
        else if (row.typed)
            pending_basis.push_back(row.exp_word);
        else
            predict_basis(row.u, row.sp, row.dg, row.all);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
    endtask

    function automatic logic knots_ready(input int sp, input int dg);
        if (sp < dg || sp + dg >= BBE_KNOT_DEPTH)
            return 1'b1;
        for (int j = sp - dg + 1; j <= sp + dg; j++)
            if (!knot_known[j])
                return 1'b0;
        return 1'b1;
    endfunction

    initial
    begin
        stim_row_t row;
        int        sp, dg;
        logic [KNOT_W-1:0] lo, hi;

        idle_pct = 27;
        start = 1'b0;
        kind = KIND_WRITE;
        knot_index = '0;
        knot_value = '0;
        param_u = '0;
        span = '0;
        degree = '0;
        all_levels = 1'b0;
        for (int j = 0; j < BBE_KNOT_DEPTH; j++)
        begin
            knot_copy[j] = '0;
            knot_known[j] = 1'b0;
        end

        dir_table = '{
            '{KIND_WRITE, 6'd0,  32'h0000_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd1,  32'h0001_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd2,  32'h0002_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd3,  32'h0003_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd4,  32'h0004_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd5,  32'h0005_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd6,  32'h0006_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd7,  32'h0007_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd60, 32'hFFFE_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd61, 32'hFFFF_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd62, 32'hFFFF_0000, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_WRITE, 6'd63, 32'hFFFF_FFFF, 32'h0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
            '{KIND_EVAL, 6'd0, 32'h0, 32'h0003_8000, 6'd3, 2'd0, 1'b0, 1'b1,
              '{2'd0, 2'd0, ONE_Q30, 1'b0, 1'b1}},
            '{KIND_EVAL, 6'd0, 32'h0, 32'h0001_0000, 6'd1, 2'd3, 1'b1, 1'b1,
              '{2'd3, 2'd0, 31'd0, 1'b1, 1'b1}},
            '{KIND_EVAL, 6'd0, 32'h0, 32'hFFFF_FFFF, 6'd62, 2'd2, 1'b0, 1'b1,
              '{2'd2, 2'd0, 31'd0, 1'b1, 1'b1}},
            '{KIND_EVAL, 6'd0, 32'h0, 32'h0, 6'd0, 2'd1, 1'b1, 1'b1,
              '{2'd1, 2'd0, 31'd0, 1'b1, 1'b1}},
            '{KIND_EVAL, 6'd0, 32'h0, 32'h0003_8000, 6'd3, 2'd3, 1'b1, 1'b0, '0},
            '{KIND_EVAL, 6'd0, 32'h0, 32'h0003_0000, 6'd3, 2'd3, 1'b0, 1'b0, '0},
            '{KIND_EVAL, 6'd0, 32'h0, 32'h0000_0000, 6'd4, 2'd2, 1'b1, 1'b0, '0},
            '{KIND_EVAL, 6'd0, 32'h0, 32'hFFFF_FFFF, 6'd2, 2'd1, 1'b1, 1'b0, '0},
            '{KIND_EVAL, 6'd0, 32'h0, 32'hFFFF_FFFF, 6'd61, 2'd2, 1'b1, 1'b0, '0},
            '{KIND_EVAL, 6'd0, 32'h0, 32'hFFFF_0000, 6'd61, 2'd1, 1'b0, 1'b0, '0}
        };

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < NUM_ROWS; n++)
            issue_word(dir_table[n]);

        for (int n = 0; n < 100; n++)
        begin
            if (n == 33)
                idle_pct = 47;
            if (n == 67)
                idle_pct = 0;
            row = '{KIND_EVAL, 6'($urandom), $urandom, $urandom, 6'($urandom),
                    2'($urandom), 1'($urandom), 1'b0, '0};
            sp = row.sp;
            dg = row.dg;
            if ($urandom_range(99) < 25 || !knots_ready(sp, dg))
            begin
                row.knd = KIND_WRITE;
                if (!knots_ready(sp, dg) && $urandom_range(99) < 70)
                    for (int j = sp + dg; j >= sp - dg + 1; j--)
                        if (!knot_known[j])
                            row.idx = j[5:0];
                if ($urandom_range(99) < 85)
                    row.kval = {10'd0, row.idx, 16'($urandom)};
            end
            else if (sp >= dg && sp + dg < BBE_KNOT_DEPTH && $urandom_range(99) < 85)
            begin
                lo = knot_copy[sp];
                hi = (sp + 1 < BBE_KNOT_DEPTH && knot_known[sp + 1]) ? knot_copy[sp + 1] : lo;
                if (hi > lo)
                    row.u = lo + ($urandom % (hi - lo));
            end
            issue_word(row);
        end
        start = 1'b0;

        wait (pending_basis.size() == 0);
        repeat (500) @(posedge clk);
        if (mismatches == 0 && pending_basis.size() == 0)
            $display("bspline_basis_eval: match");
        else
            $display("bspline_basis_eval: mismatch");
        $finish;
    end

endmodule
